[hw/rtl/nfia_pkg.sv]
// Shared types and constants for the next-fit identifier allocator.
// Sizes the bitmap memory from ID_WIDTH; no dependencies.
package nfia_pkg;

   localparam int ID_WIDTH  = 10;
   localparam int RESULT_W  = 10;
   localparam int KIND_W    = 2;
   localparam int DATA_W    = 16;
   localparam int WORD_LG   = (ID_WIDTH >= 6) ? 5 : ID_WIDTH - 1;
   localparam int ROW_LG    = ID_WIDTH - WORD_LG;
   localparam int WORD_BITS = 1 << WORD_LG;
   localparam int ROWS      = 1 << ROW_LG;

   typedef logic [ID_WIDTH-1:0]  id_type;
   typedef logic [ROW_LG-1:0]    row_type;
   typedef logic [WORD_LG-1:0]   bitpos_type;
   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [ROW_LG:0]      visit_type;
   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [1:0]           status_type;

   localparam kind_type REQ_ALLOC  = 2'd0;
   localparam kind_type REQ_ADD    = 2'd1;
   localparam kind_type REQ_REMOVE = 2'd2;

   localparam status_type STS_DONE     = 2'd0;
   localparam status_type STS_FULL     = 2'd1;
   localparam status_type STS_NOCHANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

[hw/rtl/next_fit_id_allocator_core.sv]
// Next-fit identifier allocator: in-use bitmap in a word-wide synchronous memory.
// Depends on nfia_pkg.
//
// Each request word returns exactly one response word. Add and remove pass
// through accept, memory read, bit check and write-back, in that order.
// Allocate scans the bitmap one memory word per cycle starting at the word that
// holds seed+1, and visits at most ROWS+1 words (33 for a full 1024-entry map).
// One request is in flight at a time; the next is accepted once the response
// is registered, even while that response still waits for rsp_tready. Per-word
// valid flops stand in for a clearing pass, so the block accepts requests
// straight after reset.
module next_fit_id_allocator_core
   import nfia_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [9:0] req_id
   input  logic [KIND_W-1:0] req_tuser,   // [1:0] req_type
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [9:0] result_id
   output logic [1:0]        rsp_tuser    // [1:0] status
);

   state_type  state_ff, state_in;

   kind_type   kind_ff;
   id_type     base_ff;
   id_type     seed_ff;
   row_type    row_ff;
   visit_type  visit_ff;

   word_type   mem_ram [ROWS];
   logic [ROWS-1:0] row_valid_ff;
   word_type   rd_word_ff;
   logic       rd_valid_ff;

   logic       wr_en_ff;
   row_type    wr_row_ff;
   word_type   wr_word_ff;
   id_type     res_id_ff;
   status_type res_sts_ff;
   logic       seed_upd_ff;

   logic                rsp_valid_ff;
   logic [RESULT_W-1:0] rsp_id_ff;
   status_type          rsp_sts_ff;

   logic       accept;
   logic       out_free;
   logic       rd_en;
   row_type    rd_row;
   logic       ram_we;

   word_type   eff_word;
   row_type    base_row;
   bitpos_type base_lo;
   word_type   head_mask;
   word_type   visit_mask;
   word_type   excl_mask;
   word_type   free_vec;
   logic       found;
   bitpos_type free_pos;
   logic       last_visit;
   logic       hit;
   word_type   onehot;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign eff_word   = rd_valid_ff ? rd_word_ff : '0;
   assign base_row   = base_ff[ID_WIDTH-1:WORD_LG];
   assign base_lo    = base_ff[WORD_LG-1:0];
   assign head_mask  = {WORD_BITS{1'b1}} << base_lo;
   assign last_visit = (visit_ff == visit_type'(ROWS));
   assign hit        = eff_word[base_lo];
   assign onehot     = word_type'(1) << base_lo;

   always_comb begin
      if (visit_ff == '0) begin
         visit_mask = head_mask;
      end else if (last_visit) begin
         visit_mask = ~head_mask;
      end else begin
         visit_mask = '1;
      end
   end

   always_comb begin
      excl_mask = '0;
      if (row_ff == seed_ff[ID_WIDTH-1:WORD_LG]) begin
         excl_mask = excl_mask | (word_type'(1) << seed_ff[WORD_LG-1:0]);
      end
      if (row_ff == '0) begin
         excl_mask = excl_mask | word_type'(1);
      end
   end

   assign free_vec = ~eff_word & visit_mask & ~excl_mask;
   assign found    = |free_vec;

   always_comb begin
      free_pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_pos = bitpos_type'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = (kind_ff == REQ_ALLOC) ? ST_SCAN : ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (found || last_visit) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      rd_row     = base_row;
      ram_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_READ: begin
            rd_en  = 1'b1;
            rd_row = base_row;
         end
         ST_SCAN: begin
            rd_en  = 1'b1;
            rd_row = row_ff + row_type'(1);
         end
         ST_FINISH: begin
            ram_we = out_free && wr_en_ff;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         mem_ram[wr_row_ff] <= wr_word_ff;
      end
      if (rd_en) begin
         rd_word_ff  <= mem_ram[rd_row];
         rd_valid_ff <= row_valid_ff[rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         seed_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (seed_upd_ff) seed_ff <= res_id_ff;
            if (wr_en_ff) row_valid_ff[wr_row_ff] <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_tuser;
         if (req_tuser == REQ_ALLOC) begin
            base_ff <= seed_ff + id_type'(1);
         end else begin
            base_ff <= id_type'(req_tdata[RESULT_W-1:0]);
         end
      end
      case (state_ff)
         ST_READ: begin
            row_ff   <= base_row;
            visit_ff <= '0;
         end
         ST_SCAN: begin
            if (found) begin
               wr_en_ff    <= 1'b1;
               wr_row_ff   <= row_ff;
               wr_word_ff  <= eff_word | (word_type'(1) << free_pos);
               res_id_ff   <= {row_ff, free_pos};
               res_sts_ff  <= STS_DONE;
               seed_upd_ff <= 1'b1;
            end else if (last_visit) begin
               wr_en_ff    <= 1'b0;
               res_id_ff   <= '0;
               res_sts_ff  <= STS_FULL;
               seed_upd_ff <= 1'b0;
            end else begin
               row_ff   <= row_ff + row_type'(1);
               visit_ff <= visit_ff + visit_type'(1);
            end
         end
         ST_CHECK: begin
            wr_row_ff   <= base_row;
            res_id_ff   <= base_ff;
            seed_upd_ff <= 1'b0;
            wr_en_ff    <= 1'b0;
            res_sts_ff  <= STS_NOCHANGE;
            case (kind_ff)
               REQ_ADD: begin
                  if (base_ff != '0 && !hit) begin
                     wr_en_ff   <= 1'b1;
                     wr_word_ff <= eff_word | onehot;
                     res_sts_ff <= STS_DONE;
                  end
               end
               REQ_REMOVE: begin
                  if (hit) begin
                     wr_en_ff   <= 1'b1;
                     wr_word_ff <= eff_word & ~onehot;
                     res_sts_ff <= STS_DONE;
                  end
               end
               default: begin
                  wr_en_ff <= 1'b0;
               end
            endcase
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_id_ff  <= RESULT_W'(res_id_ff);
               rsp_sts_ff <= res_sts_ff;
            end
         end
         default: begin
            wr_en_ff <= wr_en_ff;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_id_ff);
   assign rsp_tuser  = rsp_sts_ff;

endmodule
